[src/bsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants, types and blend arithmetic for the bilinear RGBA sampler.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Texel index widths and the four-bank split (column and row parity).
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int BANK_CNT  = 4;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / BANK_CNT;
  localparam int BANK_AW   = X_W + Y_W - 2;

  localparam int SIZE_W    = 9;    // width of the size registers
  localparam int COORD_W   = 17;   // unsigned Q16 coordinate
  localparam int FRAC_W    = 16;
  localparam int POS_W     = COORD_W + SIZE_W;   // scaled coordinate
  localparam int IDX_W     = POS_W - FRAC_W;     // integer part of it
  localparam int PIX_W     = 32;
  localparam int LANE_W    = 8;
  localparam int LANE_CNT  = PIX_W / LANE_W;

  localparam logic [POS_W-1:0] HALF_TEXEL = POS_W'(32'h8000);

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input operation codes.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [LANE_W-1:0] weight_t;

  // One lane: (lo*(256-w) + hi*w) >> 8.
  function automatic logic [LANE_W-1:0] mix_lane(input logic [LANE_W-1:0] lo,
                                                 input logic [LANE_W-1:0] hi,
                                                 input weight_t           w);
    logic [LANE_W:0]     w_inv;
    logic [2*LANE_W:0]   acc;
    w_inv = (LANE_W+1)'(1 << LANE_W) - {1'b0, w};
    acc   = (2*LANE_W+1)'(lo * w_inv) + (2*LANE_W+1)'(hi * {1'b0, w});
    return acc[2*LANE_W-1:LANE_W];
  endfunction

  function automatic pixel_t mix_pixel(input pixel_t a, input pixel_t b,
                                       input weight_t w);
    pixel_t r;
    for (int s = 0; s < LANE_CNT; s++) begin
      r[s*LANE_W +: LANE_W] = mix_lane(a[s*LANE_W +: LANE_W],
                                       b[s*LANE_W +: LANE_W], w);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/bsr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/bilinear_rgba_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_rgba_sampler
// Pixel store with a four-texel-per-cycle bilinear RGBA sample pipeline.
// ----------------------------------------------------------------------------
// The sampler takes one transfer per clock on the input channel, pixel
// writes and sample requests mixed freely. A write lands in the pixel store
// at the edge of its transfer and yields no result. A sample's result enters
// an eight-entry output queue through registered steps: the coordinates are
// scaled and registered at the transfer edge, then come the store read, the
// two horizontal blends and the vertical blend, which is written into the
// queue. The store is split into four banks by column and row parity, so
// the four neighbours of any sample always sit in different banks (or
// coincide after edge clamping) and are read in the same clock; this is what
// holds the rate at one item per clock. in_ready drops only when the queue
// plus the samples in flight would fill it, i.e. when the result side has
// stalled long enough. A sample never sees a write that came after it and
// always sees every write that came before it. Pixels that were never
// written read as unknown. Width and height are written through the
// APB-style port (width at 0x0, height at 0x4); the user must write them
// only while the sampler is idle, and the block does not enforce it. A zero
// size makes every sample return zero and sizes above 256 act as 256.
// ----------------------------------------------------------------------------
module bilinear_rgba_sampler
  import bsr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [7:0]         in_write_x,
  input  wire logic [7:0]         in_write_y,
  input  wire logic [31:0]        in_write_color,
  input  wire logic [16:0]        in_coord_u,
  input  wire logic [16:0]        in_coord_v,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [31:0]        out_sample_color,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              cfg_wr;
  logic              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  width_nxt  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Effective sizes: saturate at the store dimensions.
  logic [SIZE_W-1:0] w_eff, h_eff, w_top, h_top;
  assign w_eff = (width_r  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_r;
  assign h_eff = (height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_r;
  assign w_top = w_eff - SIZE_W'(1);
  assign h_top = h_eff - SIZE_W'(1);

  // --------------------------------------------------------------------------
  // Input transfer
  // --------------------------------------------------------------------------
  logic in_xfer, smp_xfer, wr_xfer;
  assign in_xfer  = in_valid & in_ready;
  assign smp_xfer = in_xfer & (in_func == FUNC_SAMPLE);
  assign wr_xfer  = in_xfer & (in_func == FUNC_WRITE);

  // --------------------------------------------------------------------------
  // Stage 1: scale coordinates, t = c*size + half texel (bias of one texel
  // folded in so t stays non-negative).
  // --------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [POS_W-1:0] s1_tu_r, s1_tv_r;
  logic             s1_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= smp_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      s1_tu_r   <= POS_W'(in_coord_u) * POS_W'(w_eff) + HALF_TEXEL;
      s1_tv_r   <= POS_W'(in_coord_v) * POS_W'(h_eff) + HALF_TEXEL;
      s1_zero_r <= (w_eff == '0) | (h_eff == '0);
    end
  end

  // Split into clamped neighbour pairs.
  logic [IDX_W-1:0] qx, qy;
  logic [X_W-1:0]   x0, x1;
  logic [Y_W-1:0]   y0, y1;

  assign qx = s1_tu_r[POS_W-1:FRAC_W];
  assign qy = s1_tv_r[POS_W-1:FRAC_W];

  always_comb begin
    if (qx == '0) begin
      x0 = '0;
    end else if ((qx - IDX_W'(1)) > IDX_W'(w_top)) begin
      x0 = w_top[X_W-1:0];
    end else begin
      x0 = X_W'(qx - IDX_W'(1));
    end
    x1 = (qx > IDX_W'(w_top)) ? w_top[X_W-1:0] : qx[X_W-1:0];

    if (qy == '0) begin
      y0 = '0;
    end else if ((qy - IDX_W'(1)) > IDX_W'(h_top)) begin
      y0 = h_top[Y_W-1:0];
    end else begin
      y0 = Y_W'(qy - IDX_W'(1));
    end
    y1 = (qy > IDX_W'(h_top)) ? h_top[Y_W-1:0] : qy[Y_W-1:0];
  end

  // Per parity, pick the neighbour column / row that lives in that bank.
  logic [X_W-2:0] col_even, col_odd;
  logic [Y_W-2:0] row_even, row_odd;
  assign col_even = (x0[0] == 1'b0) ? x0[X_W-1:1] : x1[X_W-1:1];
  assign col_odd  = (x0[0] == 1'b1) ? x0[X_W-1:1] : x1[X_W-1:1];
  assign row_even = (y0[0] == 1'b0) ? y0[Y_W-1:1] : y1[Y_W-1:1];
  assign row_odd  = (y0[0] == 1'b1) ? y0[Y_W-1:1] : y1[Y_W-1:1];

  // --------------------------------------------------------------------------
  // Pixel store: four banks indexed {row parity, column parity}.
  // --------------------------------------------------------------------------
  logic [BANK_AW-1:0] bank_raddr [BANK_CNT];
  pixel_t             bank_rdata [BANK_CNT];
  logic [BANK_AW-1:0] wr_addr;
  logic [1:0]         wr_bank;

  assign wr_addr = {in_write_y[Y_W-1:1], in_write_x[X_W-1:1]};
  assign wr_bank = {in_write_y[0], in_write_x[0]};

  assign bank_raddr[0] = {row_even, col_even};
  assign bank_raddr[1] = {row_even, col_odd};
  assign bank_raddr[2] = {row_odd,  col_even};
  assign bank_raddr[3] = {row_odd,  col_odd};

  for (genvar b = 0; b < BANK_CNT; b++) begin : g_bank
    bsr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (wr_xfer && (wr_bank == 2'(b))),
      .waddr (wr_addr),
      .wdata (in_write_color),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: store read in flight; carry parities and weights.
  // --------------------------------------------------------------------------
  logic    s2_valid_r;
  logic    s2_x0b_r, s2_x1b_r, s2_y0b_r, s2_y1b_r;
  weight_t s2_wx_r, s2_wy_r;
  logic    s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_x0b_r  <= x0[0];
      s2_x1b_r  <= x1[0];
      s2_y0b_r  <= y0[0];
      s2_y1b_r  <= y1[0];
      s2_wx_r   <= s1_tu_r[FRAC_W-1:FRAC_W-LANE_W];
      s2_wy_r   <= s1_tv_r[FRAC_W-1:FRAC_W-LANE_W];
      s2_zero_r <= s1_zero_r;
    end
  end

  // Route bank outputs to the four neighbours, then blend horizontally.
  pixel_t p00, p10, p01, p11;
  assign p00 = bank_rdata[{s2_y0b_r, s2_x0b_r}];
  assign p10 = bank_rdata[{s2_y0b_r, s2_x1b_r}];
  assign p01 = bank_rdata[{s2_y1b_r, s2_x0b_r}];
  assign p11 = bank_rdata[{s2_y1b_r, s2_x1b_r}];

  // --------------------------------------------------------------------------
  // Stage 3: horizontal blends registered.
  // --------------------------------------------------------------------------
  logic    s3_valid_r;
  pixel_t  s3_top_r, s3_bot_r;
  weight_t s3_wy_r;
  logic    s3_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_top_r  <= mix_pixel(p00, p10, s2_wx_r);
      s3_bot_r  <= mix_pixel(p01, p11, s2_wx_r);
      s3_wy_r   <= s2_wy_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // Vertical blend feeds the output queue directly.
  pixel_t result;
  assign result = s3_zero_r ? '0 : mix_pixel(s3_top_r, s3_bot_r, s3_wy_r);

  // --------------------------------------------------------------------------
  // Output queue. The pipeline never stalls; in_ready reserves a slot for
  // every sample still in flight.
  // --------------------------------------------------------------------------
  pixel_t          q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] q_wptr_r, q_wptr_nxt;
  logic [Q_AW-1:0] q_rptr_r, q_rptr_nxt;
  logic [Q_AW:0]   q_cnt_r, q_cnt_nxt;
  logic            q_push, q_pop;
  logic [Q_AW:0]   pending;

  assign q_push = s3_valid_r;
  assign q_pop  = out_valid & out_ready;

  assign pending = q_cnt_r + (Q_AW+1)'(s1_valid_r) + (Q_AW+1)'(s2_valid_r)
                 + (Q_AW+1)'(s3_valid_r);
  assign in_ready = (pending < (Q_AW+1)'(Q_DEPTH));

  assign out_valid        = (q_cnt_r != '0);
  assign out_sample_color = q_mem_r[q_rptr_r];

  always_comb begin
    q_wptr_nxt = q_push ? q_wptr_r + Q_AW'(1) : q_wptr_r;
    q_rptr_nxt = q_pop  ? q_rptr_r + Q_AW'(1) : q_rptr_r;
    q_cnt_nxt  = q_cnt_r + (Q_AW+1)'(q_push) - (Q_AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= '0;
      q_rptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_wptr_r <= q_wptr_nxt;
      q_rptr_r <= q_rptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wptr_r] <= result;
    end
  end

endmodule
`default_nettype wire
